// ----- rtl/fcc_neighbor_count_core_defines.svh -----
// Assertion macros shared by the neighbor count core.
`ifndef FCC_NEIGHBOR_COUNT_CORE_DEFINES_SVH
`define FCC_NEIGHBOR_COUNT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define FCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define FCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fcc_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and the neighbor offset table of the neighbor count core.
package fcc_pkg;

  localparam int MAX_SIDE  = 32;
  localparam int CSEL_W    = $clog2(MAX_SIDE);
  localparam int ADDR_W    = 3 * CSEL_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  localparam int COORD_W   = 5;
  localparam int SIZE_W    = 6;
  localparam int NC_W      = 7;
  localparam int STEP_W    = 4;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [NC_W-1:0]      MAX_SIDE_NC = NC_W'(MAX_SIDE);
  localparam logic [SIZE_W-1:0]    SIZE_RESET  = 6'd32;
  localparam logic [STEP_W-1:0]    STEP_SITE   = 4'd0;
  localparam logic [STEP_W-1:0]    STEP_LAST   = 4'd12;
  localparam logic [CNT_W-1:0]     CNT_MAX     = 4'd12;

  localparam logic                 REQ_WRITE   = 1'b0;
  localparam logic                 REQ_QUERY   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 2'd2;

  // Two's complement offsets of one step along an axis.
  localparam logic [1:0] OFF_M = 2'b11;
  localparam logic [1:0] OFF_Z = 2'b00;
  localparam logic [1:0] OFF_P = 2'b01;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_QUERY,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } site_t;

  typedef struct packed {
    logic [NC_W-1:0] sx;
    logic [NC_W-1:0] sy;
    logic [NC_W-1:0] sz;
  } dims_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              in_range;
  } au_out_t;

  typedef struct packed {
    logic [1:0] dx;
    logic [1:0] dy;
    logic [1:0] dz;
  } offset_t;

  // Sizes above the grid side behave as the grid side.
  function automatic logic [NC_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [NC_W-1:0] s_ext;
    s_ext = {{(NC_W-SIZE_W){1'b0}}, s};
    eff_size = (s_ext > MAX_SIDE_NC) ? MAX_SIDE_NC : s_ext;
  endfunction

  // Step zero addresses the site itself; steps one to twelve its neighbors.
  function automatic offset_t nb_off(input logic [STEP_W-1:0] k);
    offset_t o;
    case (k)
      4'd1:    o = '{OFF_M, OFF_M, OFF_Z};
      4'd2:    o = '{OFF_M, OFF_P, OFF_Z};
      4'd3:    o = '{OFF_P, OFF_M, OFF_Z};
      4'd4:    o = '{OFF_P, OFF_P, OFF_Z};
      4'd5:    o = '{OFF_Z, OFF_M, OFF_P};
      4'd6:    o = '{OFF_M, OFF_Z, OFF_P};
      4'd7:    o = '{OFF_P, OFF_Z, OFF_P};
      4'd8:    o = '{OFF_Z, OFF_P, OFF_P};
      4'd9:    o = '{OFF_Z, OFF_M, OFF_M};
      4'd10:   o = '{OFF_M, OFF_Z, OFF_M};
      4'd11:   o = '{OFF_P, OFF_Z, OFF_M};
      4'd12:   o = '{OFF_Z, OFF_P, OFF_M};
      default: o = '{OFF_Z, OFF_Z, OFF_Z};
    endcase
    nb_off = o;
  endfunction

endpackage

// ----- rtl/fcc_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port RAM with a registered read.
module fcc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/fcc_addr_unit.sv -----
`timescale 1ns / 1ps
// Shared address unit: offsets a site by one table step and checks the bounds.
module fcc_addr_unit (
  input  fcc_pkg::site_t                 site,
  input  logic [fcc_pkg::STEP_W-1:0]     step,
  input  fcc_pkg::dims_t                 dims,
  output fcc_pkg::au_out_t               result
);

  fcc_pkg::offset_t           off;
  logic [fcc_pkg::NC_W-1:0]   nx;
  logic [fcc_pkg::NC_W-1:0]   ny;
  logic [fcc_pkg::NC_W-1:0]   nz;

  // A step below zero wraps to the top of the range and fails the bound check.
  always_comb begin
    off = fcc_pkg::nb_off(step);
    nx  = {{(fcc_pkg::NC_W-fcc_pkg::COORD_W){1'b0}}, site.x}
        + {{(fcc_pkg::NC_W-2){off.dx[1]}}, off.dx};
    ny  = {{(fcc_pkg::NC_W-fcc_pkg::COORD_W){1'b0}}, site.y}
        + {{(fcc_pkg::NC_W-2){off.dy[1]}}, off.dy};
    nz  = {{(fcc_pkg::NC_W-fcc_pkg::COORD_W){1'b0}}, site.z}
        + {{(fcc_pkg::NC_W-2){off.dz[1]}}, off.dz};
    result.in_range = (nx < dims.sx) && (ny < dims.sy) && (nz < dims.sz);
    result.addr     = {nx[fcc_pkg::CSEL_W-1:0], ny[fcc_pkg::CSEL_W-1:0],
                       nz[fcc_pkg::CSEL_W-1:0]};
  end

endmodule

// ----- rtl/fcc_neighbor_count_core.sv -----
`timescale 1ns / 1ps
// Top level of the lattice occupancy store with nearest neighbor counting.
//
//  channel | ports                                             | handshake
//  --------+---------------------------------------------------+-----------------
//  in      | in_req_type in_x in_y in_z in_occupied            | in_valid/in_ready
//  out     | out_neighbor_count out_site_occupied              | out_valid/out_ready
//          | out_bad_coordinate                                |
//  cfg     | cfg_index cfg_data                                | cfg_we, no wait
//
// A query makes 13 reads of the single-port bitmap RAM (the site, then twelve
// neighbors), then passes a drain state and a load state that fills the result
// register. A write passes the write and load states, a bad coordinate only the
// load state. The core then returns to idle, where the next word is taken.
// After reset the bitmap is cleared one bit a cycle over all 2**ADDR_W addresses
// (32768 for a side of 32), with in_ready low; cfg writes are taken meanwhile.
// The result register lets the next word be accepted while the last result
// still waits on out_ready.
`include "fcc_neighbor_count_core_defines.svh"

module fcc_neighbor_count_core (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [fcc_pkg::COORD_W-1:0]     in_x,
  input  logic [fcc_pkg::COORD_W-1:0]     in_y,
  input  logic [fcc_pkg::COORD_W-1:0]     in_z,
  input  logic                            in_occupied,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fcc_pkg::CNT_W-1:0]       out_neighbor_count,
  output logic                            out_site_occupied,
  output logic                            out_bad_coordinate,

  input  logic                            cfg_we,
  input  logic [fcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcc_pkg::SIZE_W-1:0]      cfg_data
);

  fcc_pkg::state_t                 state_r, state_nxt;
  logic [fcc_pkg::ADDR_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic [fcc_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic                            rd_pend_r, rd_pend_nxt;
  logic                            rd_site_r, rd_site_nxt;
  logic                            rd_use_r, rd_use_nxt;
  logic                            out_valid_r, out_valid_nxt;

  logic [fcc_pkg::SIZE_W-1:0]      size_x_r, size_y_r, size_z_r;

  logic                            req_r, req_nxt;
  fcc_pkg::site_t                  site_r, site_nxt;
  logic                            occ_r, occ_nxt;
  logic                            bad_r, bad_nxt;
  logic [fcc_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            here_r, here_nxt;
  logic [fcc_pkg::CNT_W-1:0]       out_cnt_r, out_cnt_nxt;
  logic                            out_site_r, out_site_nxt;
  logic                            out_bad_r, out_bad_nxt;

  fcc_pkg::site_t                  site_sel;
  fcc_pkg::dims_t                  dims;
  fcc_pkg::au_out_t                au;
  logic                            par_even;
  logic                            accept;

  logic                            ram_we;
  logic [fcc_pkg::ADDR_W-1:0]      ram_addr;
  logic [0:0]                      ram_wdata;
  logic [0:0]                      ram_rdata;

  assign in_ready = (state_r == fcc_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign dims.sx = fcc_pkg::eff_size(size_x_r);
  assign dims.sy = fcc_pkg::eff_size(size_y_r);
  assign dims.sz = fcc_pkg::eff_size(size_z_r);

  // While idle the unit looks at the incoming word so the bound check is ready
  // at acceptance.
  assign site_sel = (state_r == fcc_pkg::ST_IDLE) ? {in_x, in_y, in_z} : site_r;
  assign par_even = ~(site_r.x[0] ^ site_r.y[0] ^ site_r.z[0]);

  fcc_addr_unit u_addr (
    .site   (site_sel),
    .step   (step_r),
    .dims   (dims),
    .result (au)
  );

  fcc_ram #(
    .WIDTH (1),
    .DEPTH (fcc_pkg::RAM_DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= fcc_pkg::SIZE_RESET;
      size_y_r <= fcc_pkg::SIZE_RESET;
      size_z_r <= fcc_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fcc_pkg::CFG_SIZE_X: size_x_r <= cfg_data;
        fcc_pkg::CFG_SIZE_Y: size_y_r <= cfg_data;
        fcc_pkg::CFG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcc_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      step_r      <= fcc_pkg::STEP_SITE;
      rd_pend_r   <= 1'b0;
      rd_site_r   <= 1'b0;
      rd_use_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      step_r      <= step_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_site_r   <= rd_site_nxt;
      rd_use_r    <= rd_use_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    site_r     <= site_nxt;
    occ_r      <= occ_nxt;
    bad_r      <= bad_nxt;
    cnt_r      <= cnt_nxt;
    here_r     <= here_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_site_r <= out_site_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    step_nxt      = step_r;
    rd_pend_nxt   = 1'b0;
    rd_site_nxt   = 1'b0;
    rd_use_nxt    = 1'b0;
    out_valid_nxt = out_valid_r;
    req_nxt       = req_r;
    site_nxt      = site_r;
    occ_nxt       = occ_r;
    bad_nxt       = bad_r;
    cnt_nxt       = cnt_r;
    here_nxt      = here_r;
    out_cnt_nxt   = out_cnt_r;
    out_site_nxt  = out_site_r;
    out_bad_nxt   = out_bad_r;
    ram_we        = 1'b0;
    ram_addr      = au.addr;
    ram_wdata     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Read data returns in the cycle after its address was issued.
    if (rd_pend_r) begin
      if (rd_site_r) begin
        here_nxt = ram_rdata[0];
      end else if (rd_use_r && ram_rdata[0]) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    case (state_r)
      fcc_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          state_nxt = fcc_pkg::ST_IDLE;
        end
      end
      fcc_pkg::ST_IDLE: begin
        if (accept) begin
          req_nxt  = in_req_type;
          site_nxt = '{in_x, in_y, in_z};
          occ_nxt  = in_occupied;
          bad_nxt  = !au.in_range;
          cnt_nxt  = '0;
          here_nxt = 1'b0;
          step_nxt = fcc_pkg::STEP_SITE;
          if (!au.in_range) begin
            state_nxt = fcc_pkg::ST_DONE;
          end else if (in_req_type == fcc_pkg::REQ_WRITE) begin
            state_nxt = fcc_pkg::ST_WRITE;
          end else begin
            state_nxt = fcc_pkg::ST_QUERY;
          end
        end
      end
      fcc_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = occ_r;
        here_nxt  = occ_r;
        state_nxt = fcc_pkg::ST_DONE;
      end
      fcc_pkg::ST_QUERY: begin
        rd_pend_nxt = 1'b1;
        rd_site_nxt = (step_r == fcc_pkg::STEP_SITE);
        rd_use_nxt  = au.in_range && par_even;
        step_nxt    = step_r + 1'b1;
        if (step_r == fcc_pkg::STEP_LAST) begin
          state_nxt = fcc_pkg::ST_DRAIN;
        end
      end
      fcc_pkg::ST_DRAIN: begin
        state_nxt = fcc_pkg::ST_DONE;
      end
      fcc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cnt_r;
          out_site_nxt  = here_r;
          out_bad_nxt   = bad_r;
          state_nxt     = fcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fcc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_neighbor_count = out_cnt_r;
  assign out_site_occupied  = out_site_r;
  assign out_bad_coordinate = out_bad_r;

  `FCC_ASSERT_IMP(a_cnt_range, out_valid_r, out_cnt_r <= fcc_pkg::CNT_MAX, "count above twelve")
  `FCC_ASSERT_IMP(a_bad_zero, out_valid_r && out_bad_r, (out_cnt_r == '0) && !out_site_r, "bad word with nonzero fields")
  `FCC_ASSERT_IMP(a_write_cnt, (state_r == fcc_pkg::ST_DONE) && (req_r == fcc_pkg::REQ_WRITE), cnt_r == '0, "write word with nonzero count")
  `FCC_ASSERT_NXT(a_clear_end, (state_r == fcc_pkg::ST_CLEAR) && (&clr_addr_r), state_r == fcc_pkg::ST_IDLE, "clear pass did not end")

endmodule
